[sv/laser_polar_to_cartesian_top_macros.svh]
// Assertion macros for the laser polar-to-Cartesian projector.
// Used by the port checker; needs nothing else.
`ifndef LASER_POLAR_TO_CARTESIAN_TOP_MACROS_SVH
`define LASER_POLAR_TO_CARTESIAN_TOP_MACROS_SVH

// Property checked on every rising clock edge, ignored while reset is high.
`define LPC_ASSERT_OUT_OF_RESET(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define LPC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/lpc_pkg.sv]
// Shared types, register codes and the CORDIC arctangent table for the
// laser polar-to-Cartesian projector. Depends on nothing.
`default_nettype none

package lpc_pkg;

  // Fixed field widths
  localparam int BEAM_INDEX_W = 12;
  localparam int RANGE_W      = 16;
  localparam int STRENGTH_W   = 16;
  localparam int ANGLE_W      = 24;
  localparam int RESIDUE_W    = 22;
  localparam int COORD_W      = 17;
  localparam int TRIG_W       = 17;
  localparam int CX_W         = 18;   // CORDIC x / y width
  localparam int CZ_W         = 25;   // CORDIC residual angle width
  localparam int TABLE_LEN    = 24;

  // Configuration port
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 24;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_RANGE   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_RANGE   = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_START_ANGLE = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_STEP  = 8'd3;

  // Gain-compensated CORDIC start value, 0.60725 in Q15
  localparam logic signed [CX_W-1:0] CORDIC_X0 = 18'sd19898;
  // Trig saturation bound, 1.0 in Q15
  localparam logic signed [CX_W-1:0] TRIG_ONE  = 18'sd32768;

  // Configuration register set
  typedef struct packed {
    logic [RANGE_W-1:0] min_range_mm;
    logic [RANGE_W-1:0] max_range_mm;
    logic [ANGLE_W-1:0] start_angle;
    logic [ANGLE_W-1:0] angle_step;
  } lpc_cfg_t;

  // Per-item data that rides along the pipeline
  typedef struct packed {
    logic                  in_win;
    logic [1:0]            quad;
    logic [RANGE_W-1:0]    range_mm;
    logic [STRENGTH_W-1:0] strength;
  } beam_side_t;

  // One finished point
  typedef struct packed {
    logic                  valid;
    logic [STRENGTH_W-1:0] strength;
    logic [COORD_W-1:0]    y;
    logic [COORD_W-1:0]    x;
  } point_t;

  // atan(2^-k) in 2^-24 turn, rounded to nearest
  function automatic logic [RESIDUE_W-1:0] atan_turn(input int unsigned k);
    logic [RESIDUE_W-1:0] v;
    case (k)
      0:       v = 22'd2097152;
      1:       v = 22'd1238021;
      2:       v = 22'd654136;
      3:       v = 22'd332050;
      4:       v = 22'd166669;
      5:       v = 22'd83416;
      6:       v = 22'd41718;
      7:       v = 22'd20860;
      8:       v = 22'd10430;
      9:       v = 22'd5215;
      10:      v = 22'd2608;
      11:      v = 22'd1304;
      12:      v = 22'd652;
      13:      v = 22'd326;
      14:      v = 22'd163;
      15:      v = 22'd81;
      16:      v = 22'd41;
      17:      v = 22'd20;
      18:      v = 22'd10;
      19:      v = 22'd5;
      20:      v = 22'd3;
      21:      v = 22'd1;
      22:      v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[sv/lpc_angle.sv]
// Beam angle stages: index times step, then plus start angle modulo one turn.
// Also registers the range window test. Uses lpc_pkg.
`default_nettype none

module lpc_angle #(
  parameter int INDEX_BITS = 12
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           en,
  input  wire lpc_pkg::lpc_cfg_t              cfg,
  input  wire logic                           in_valid,
  input  wire logic [lpc_pkg::BEAM_INDEX_W-1:0] beam_index,
  input  wire logic [lpc_pkg::RANGE_W-1:0]    range_mm,
  input  wire logic [lpc_pkg::STRENGTH_W-1:0] echo_strength,
  output logic                                out_valid,
  output logic [lpc_pkg::RESIDUE_W-1:0]       residue,
  output lpc_pkg::beam_side_t                 out_side
);
  import lpc_pkg::*;

  // Index bits that take part in the angle
  localparam int IDX_W = (INDEX_BITS < BEAM_INDEX_W) ? INDEX_BITS : BEAM_INDEX_W;

  logic [IDX_W+ANGLE_W-1:0] prod_full;
  logic                     a_valid;
  logic [ANGLE_W-1:0]       a_prod;
  beam_side_t               a_side;
  logic [ANGLE_W-1:0]       angle;

  assign prod_full = beam_index[IDX_W-1:0] * cfg.angle_step;
  assign angle     = cfg.start_angle + a_prod;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid   <= in_valid;
      out_valid <= a_valid;
    end
  end

  // Stage A: product and window test; stage B: wrapped angle split
  always_ff @(posedge clk) begin
    if (en) begin
      a_prod            <= prod_full[ANGLE_W-1:0];
      a_side.in_win     <= (range_mm > cfg.min_range_mm) && (range_mm < cfg.max_range_mm);
      a_side.quad       <= 2'd0;
      a_side.range_mm   <= range_mm;
      a_side.strength   <= echo_strength;
      residue           <= angle[RESIDUE_W-1:0];
      out_side.in_win   <= a_side.in_win;
      out_side.quad     <= angle[ANGLE_W-1:ANGLE_W-2];
      out_side.range_mm <= a_side.range_mm;
      out_side.strength <= a_side.strength;
    end
  end

endmodule

`default_nettype wire

[sv/lpc_cordic.sv]
// Pipelined rotation-mode CORDIC, one iteration per register stage.
// Gives cos / sin of a first-quadrant residue in Q15. Uses lpc_pkg.
`default_nettype none

module lpc_cordic #(
  parameter int STAGES = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic                     in_valid,
  input  wire logic [lpc_pkg::RESIDUE_W-1:0] residue,
  input  wire lpc_pkg::beam_side_t      in_side,
  output logic                          out_valid,
  output logic signed [lpc_pkg::CX_W-1:0] cos_q,
  output logic signed [lpc_pkg::CX_W-1:0] sin_q,
  output lpc_pkg::beam_side_t           out_side
);
  import lpc_pkg::*;

  logic                   vs [0:STAGES];
  logic signed [CX_W-1:0] xs [0:STAGES];
  logic signed [CX_W-1:0] ys [0:STAGES];
  logic signed [CZ_W-1:0] zs [0:STAGES];
  beam_side_t             ss [0:STAGES];

  assign vs[0] = in_valid;
  assign xs[0] = CORDIC_X0;
  assign ys[0] = '0;
  assign zs[0] = $signed({{(CZ_W-RESIDUE_W){1'b0}}, residue});
  assign ss[0] = in_side;

  genvar k;
  generate
    for (k = 0; k < STAGES; k++) begin : g_stage
      localparam logic signed [CZ_W-1:0] ATAN_K =
        $signed({{(CZ_W-RESIDUE_W){1'b0}}, atan_turn(k)});

      always_ff @(posedge clk) begin
        if (rst) begin
          vs[k+1] <= 1'b0;
        end else if (en) begin
          vs[k+1] <= vs[k];
        end
      end

      // Rotate toward zero residual angle
      always_ff @(posedge clk) begin
        if (en) begin
          ss[k+1] <= ss[k];
          if (!zs[k][CZ_W-1]) begin
            xs[k+1] <= xs[k] - (ys[k] >>> k);
            ys[k+1] <= ys[k] + (xs[k] >>> k);
            zs[k+1] <= zs[k] - ATAN_K;
          end else begin
            xs[k+1] <= xs[k] + (ys[k] >>> k);
            ys[k+1] <= ys[k] - (xs[k] >>> k);
            zs[k+1] <= zs[k] + ATAN_K;
          end
        end
      end
    end
  endgenerate

  assign out_valid = vs[STAGES];
  assign cos_q     = xs[STAGES];
  assign sin_q     = ys[STAGES];
  assign out_side  = ss[STAGES];

endmodule

`default_nettype wire

[sv/lpc_scale.sv]
// Quadrant fold and saturation, range multiply, round to millimetres.
// Three register stages; invalid beams leave as all-zero points. Uses lpc_pkg.
`default_nettype none

module lpc_scale (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire logic signed [lpc_pkg::CX_W-1:0] cos_q,
  input  wire logic signed [lpc_pkg::CX_W-1:0] sin_q,
  input  wire lpc_pkg::beam_side_t        in_side,
  output logic                            out_valid,
  output lpc_pkg::point_t                 out_point
);
  import lpc_pkg::*;

  localparam int PROD_W = RANGE_W + TRIG_W + 1;

  logic signed [CX_W-1:0]   c_full;
  logic signed [CX_W-1:0]   s_full;
  logic signed [CX_W-1:0]   c_sat;
  logic signed [CX_W-1:0]   s_sat;
  logic                     q_valid;
  logic signed [TRIG_W-1:0] q_cos;
  logic signed [TRIG_W-1:0] q_sin;
  beam_side_t               q_side;
  logic signed [PROD_W-1:0] px_full;
  logic signed [PROD_W-1:0] py_full;
  logic                     m_valid;
  logic signed [PROD_W-1:0] m_px;
  logic signed [PROD_W-1:0] m_py;
  beam_side_t               m_side;
  logic signed [PROD_W-1:0] rx;
  logic signed [PROD_W-1:0] ry;

  // Rotate first-quadrant result into the beam's quadrant
  always_comb begin
    case (in_side.quad)
      2'd0: begin
        c_full = cos_q;
        s_full = sin_q;
      end
      2'd1: begin
        c_full = -sin_q;
        s_full = cos_q;
      end
      2'd2: begin
        c_full = -cos_q;
        s_full = -sin_q;
      end
      default: begin
        c_full = sin_q;
        s_full = -cos_q;
      end
    endcase
    c_sat = (c_full > TRIG_ONE) ? TRIG_ONE : ((c_full < -TRIG_ONE) ? -TRIG_ONE : c_full);
    s_sat = (s_full > TRIG_ONE) ? TRIG_ONE : ((s_full < -TRIG_ONE) ? -TRIG_ONE : s_full);
  end

  // Range times trig, 17 x 17 signed
  assign px_full = $signed({1'b0, q_side.range_mm}) * q_cos;
  assign py_full = $signed({1'b0, q_side.range_mm}) * q_sin;

  // Round half up, drop 15 fraction bits
  assign rx = (m_px + $signed(PROD_W'(16384))) >>> 15;
  assign ry = (m_py + $signed(PROD_W'(16384))) >>> 15;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid   <= 1'b0;
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      q_valid   <= in_valid;
      m_valid   <= q_valid;
      out_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_cos  <= c_sat[TRIG_W-1:0];
      q_sin  <= s_sat[TRIG_W-1:0];
      q_side <= in_side;
      m_px   <= px_full;
      m_py   <= py_full;
      m_side <= q_side;
      if (m_side.in_win) begin
        out_point.valid    <= 1'b1;
        out_point.strength <= m_side.strength;
        out_point.x        <= rx[COORD_W-1:0];
        out_point.y        <= ry[COORD_W-1:0];
      end else begin
        out_point <= '0;
      end
    end
  end

endmodule

`default_nettype wire

[sv/lpc_out_buf.sv]
// Output register with a one-item skid slot. Its registered enable stalls
// the whole pipeline only once both slots are full. Uses lpc_pkg.
`default_nettype none

module lpc_out_buf (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire lpc_pkg::point_t in_point,
  output logic                 en,
  output logic                 out_valid,
  output lpc_pkg::point_t      out_point,
  input  wire logic            out_ready
);
  import lpc_pkg::*;

  logic   skid_valid;
  point_t skid_point;
  logic   take;

  assign en   = !skid_valid;
  assign take = in_valid && en;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= take;
      end
    end else if (take) begin
      skid_valid <= 1'b1;
    end
  end

  // Data
  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_point <= skid_valid ? skid_point : in_point;
    end else if (take) begin
      skid_point <= in_point;
    end
  end

endmodule

`default_nettype wire

[sv/laser_polar_to_cartesian_top.sv]
// Laser beam polar-to-Cartesian projector, top level.
// Throughput: one item per cycle while the skid slot is empty. With
// m_tready low the output register plus one skid slot take one more
// item, then the pipeline holds.
// Reset (rst, synchronous): empties the pipeline, loads register defaults.
`default_nettype none

module laser_polar_to_cartesian_top #(
  parameter int CORDIC_STAGES = 16,
  parameter int INDEX_BITS    = 12
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Beam input: s_tdata = beam_index[11:0], range_mm[27:12],
  // echo_strength[43:28], zero pad [47:44]
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,
  // Point output: m_tdata = point_x[16:0], point_y[33:17],
  // point_strength[49:34], zero pad [55:50]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,
  // m_tuser = point_valid[0]
  output logic             m_tuser,
  // Configuration write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [lpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [lpc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lpc_pkg::*;

  lpc_cfg_t          cfg;
  logic              en;
  logic              ang_valid;
  logic [RESIDUE_W-1:0] ang_residue;
  beam_side_t        ang_side;
  logic              cor_valid;
  logic signed [CX_W-1:0] cor_cos;
  logic signed [CX_W-1:0] cor_sin;
  beam_side_t        cor_side;
  logic              scl_valid;
  point_t            scl_point;
  point_t            out_point;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_range_mm <= '0;
      cfg.max_range_mm <= '1;
      cfg.start_angle  <= '0;
      cfg.angle_step   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_RANGE:   cfg.min_range_mm <= cfg_data[RANGE_W-1:0];
        REG_MAX_RANGE:   cfg.max_range_mm <= cfg_data[RANGE_W-1:0];
        REG_START_ANGLE: cfg.start_angle  <= cfg_data[ANGLE_W-1:0];
        REG_ANGLE_STEP:  cfg.angle_step   <= cfg_data[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_tready = en;

  lpc_angle #(
    .INDEX_BITS(INDEX_BITS)
  ) u_angle (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .cfg          (cfg),
    .in_valid     (s_tvalid),
    .beam_index   (s_tdata[11:0]),
    .range_mm     (s_tdata[27:12]),
    .echo_strength(s_tdata[43:28]),
    .out_valid    (ang_valid),
    .residue      (ang_residue),
    .out_side     (ang_side)
  );

  lpc_cordic #(
    .STAGES(CORDIC_STAGES)
  ) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (ang_valid),
    .residue  (ang_residue),
    .in_side  (ang_side),
    .out_valid(cor_valid),
    .cos_q    (cor_cos),
    .sin_q    (cor_sin),
    .out_side (cor_side)
  );

  lpc_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (cor_valid),
    .cos_q    (cor_cos),
    .sin_q    (cor_sin),
    .in_side  (cor_side),
    .out_valid(scl_valid),
    .out_point(scl_point)
  );

  lpc_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (scl_valid),
    .in_point (scl_point),
    .en       (en),
    .out_valid(m_tvalid),
    .out_point(out_point),
    .out_ready(m_tready)
  );

  assign m_tdata = {6'b0, out_point.strength, out_point.y, out_point.x};
  assign m_tuser = out_point.valid;

endmodule

`default_nettype wire

[sv/lpc_checker.sv]
// Port-level checker for the projector, bound to the top level.
// Uses the assertion macros header.
`default_nettype none
`include "laser_polar_to_cartesian_top_macros.svh"

module lpc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [47:0] s_tdata,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [55:0] m_tdata,
  input wire logic        m_tuser
);

  // A stalled point holds
  `LPC_ASSERT_OUT_OF_RESET(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled point changed")

  // An invalid point carries all-zero fields
  `LPC_ASSERT_OUT_OF_RESET(a_invalid_zero, clk, rst, m_tvalid && !m_tuser |-> m_tdata == 56'd0, "invalid point has nonzero fields")

  // Coordinates never reach -65536 and padding stays zero
  `LPC_ASSERT_OUT_OF_RESET(a_coord_range, clk, rst, m_tvalid |-> m_tdata[16:0] != 17'h10000 && m_tdata[33:17] != 17'h10000 && m_tdata[55:50] == 6'd0, "point field out of range")

  // Reset empties the output
  `LPC_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !m_tvalid, "output valid right after reset")

  // An accepted beam carries known data
  `LPC_ASSERT_OUT_OF_RESET(a_in_known, clk, rst, s_tvalid && s_tready |-> !$isunknown(s_tdata), "accepted item has unknown bits")

endmodule

bind laser_polar_to_cartesian_top lpc_checker u_lpc_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tdata (s_tdata),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

`default_nettype wire

[dv/lpc_point_checker.sv]
// Point checker for the laser polar-to-Cartesian projector: watches the beam,
// point and register channels, predicts every point and compares it.
// Depends on lpc_pkg for the register codes, the CORDIC constants and point_t.
`timescale 1ns / 100ps

module lpc_point_checker #(
  parameter int CORDIC_STAGES = 16,
  parameter int INDEX_BITS    = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  // beam_index[11:0], range_mm[27:12], echo_strength[43:28], pad[47:44]
  input  logic [47:0]                     s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  // point_x[16:0], point_y[33:17], point_strength[49:34], pad[55:50]
  input  logic [55:0]                     m_tdata,
  // point_valid[0]
  input  logic                            m_tuser,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [lpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lpc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              fail_count,
  output int                              pending,
  output int                              points_seen,
  output int                              valid_seen
);
  import lpc_pkg::*;

  // Our copy of the register set and the points still owed by the block
  lpc_cfg_t regs;
  point_t   owed_points[$];
  int       n_bad;
  int       n_pts;
  int       n_valid;

  // atan(2^-k) in 2^-24 turn
  function automatic int arctan_turns(input int k);
    case (k)
      0:       return 2097152;
      1:       return 1238021;
      2:       return 654136;
      3:       return 332050;
      4:       return 166669;
      5:       return 83416;
      6:       return 41718;
      7:       return 20860;
      8:       return 10430;
      9:       return 5215;
      10:      return 2608;
      11:      return 1304;
      12:      return 652;
      13:      return 326;
      14:      return 163;
      15:      return 81;
      16:      return 41;
      17:      return 20;
      18:      return 10;
      19:      return 5;
      20:      return 3;
      21:      return 1;
      22:      return 1;
      default: return 0;
    endcase
  endfunction

  function automatic int clamp_unit(input int v);
    if (v > int'(TRIG_ONE)) return int'(TRIG_ONE);
    if (v < -int'(TRIG_ONE)) return -int'(TRIG_ONE);
    return v;
  endfunction

  // range * trig in Q15, rounded half up, kept to 17 bits
  function automatic logic [COORD_W-1:0] scale_mm(input logic [15:0] rng, input int trig);
    longint prod;
    prod = longint'(rng) * longint'(trig);
    prod = (prod + 64'sd16384) >>> 15;
    return prod[COORD_W-1:0];
  endfunction

  // Expected point for one beam under the current registers
  function automatic point_t project_beam(input logic [47:0] beam);
    point_t      p;
    logic [15:0] rng;
    longint      idx;
    longint      ang;
    logic [23:0] angle;
    int          x, y, z, dx, dy, c, s;
    p     = '0;
    idx   = longint'(beam[11:0]) & ((longint'(1) << INDEX_BITS) - 1);
    rng   = beam[27:12];
    if (rng > regs.min_range_mm && rng < regs.max_range_mm) begin
      ang   = longint'(regs.start_angle) + idx * longint'(regs.angle_step);
      angle = ang[23:0];
      // rotation-mode CORDIC on the residue inside the quadrant
      x = int'(CORDIC_X0);
      y = 0;
      z = int'(angle[21:0]);
      for (int k = 0; k < CORDIC_STAGES && k < TABLE_LEN; k++) begin
        dx = y >>> k;
        dy = x >>> k;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - arctan_turns(k);
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + arctan_turns(k);
        end
      end
      // quadrant folds back in as a multiple of 90 degrees
      case (angle[23:22])
        2'd0: begin
          c = x;
          s = y;
        end
        2'd1: begin
          c = -y;
          s = x;
        end
        2'd2: begin
          c = -x;
          s = -y;
        end
        default: begin
          c = y;
          s = -x;
        end
      endcase
      p.x        = scale_mm(rng, clamp_unit(c));
      p.y        = scale_mm(rng, clamp_unit(s));
      p.strength = beam[43:28];
      p.valid    = 1'b1;
    end
    return p;
  endfunction

  task automatic note_mismatch(input string what, input longint want_v, input longint got_v);
    n_bad++;
    if (n_bad <= 10)
      $display("%0t: point %0d, %s: expected %0d, got %0d", $time, n_pts, what, want_v, got_v);
  endtask

  // Watch all three channels at each rising edge
  always @(posedge clk) begin : watch
    point_t want;
    point_t got;
    if (rst) begin
      regs.min_range_mm = '0;
      regs.max_range_mm = 16'hFFFF;
      regs.start_angle  = '0;
      regs.angle_step   = '0;
      owed_points.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.x        = m_tdata[16:0];
        got.y        = m_tdata[33:17];
        got.strength = m_tdata[49:34];
        got.valid    = m_tuser;
        n_pts++;
        if (m_tuser === 1'b1) n_valid++;
        if (owed_points.size() == 0) begin
          note_mismatch("points outstanding at output", 1, 0);
        end else begin
          want = owed_points.pop_front();
          if (got.x !== want.x)
            note_mismatch("point_x", longint'($signed(want.x)), longint'($signed(got.x)));
          if (got.y !== want.y)
            note_mismatch("point_y", longint'($signed(want.y)), longint'($signed(got.y)));
          if (got.strength !== want.strength)
            note_mismatch("point_strength", want.strength, got.strength);
          if (got.valid !== want.valid)
            note_mismatch("point_valid", want.valid, got.valid);
          if (m_tdata[55:50] !== 6'd0)
            note_mismatch("tdata pad", 0, m_tdata[55:50]);
        end
      end
      if (s_tvalid && s_tready) owed_points.push_back(project_beam(s_tdata));
      // register writes; unknown indexes are dropped, data masked to width
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_RANGE:   regs.min_range_mm = cfg_data[15:0];
          REG_MAX_RANGE:   regs.max_range_mm = cfg_data[15:0];
          REG_START_ANGLE: regs.start_angle  = cfg_data[23:0];
          REG_ANGLE_STEP:  regs.angle_step   = cfg_data[23:0];
          default: ;
        endcase
      end
    end
    fail_count  <= n_bad;
    pending     <= owed_points.size();
    points_seen <= n_pts;
    valid_seen  <= n_valid;
  end

endmodule

[dv/laser_polar_to_cartesian_top_tb.sv]
// Testbench top for the laser polar-to-Cartesian projector: clock, reset,
// beam and register stimulus, receiver stalls and the verdict.
// Depends on lpc_pkg, laser_polar_to_cartesian_top and lpc_point_checker.
`timescale 1ns / 100ps

module laser_polar_to_cartesian_top_tb;
  import lpc_pkg::*;

  localparam int CORDIC_STAGES   = 16;
  localparam int INDEX_BITS      = 12;
  localparam int PIPE_CYCLES     = CORDIC_STAGES + 5;
  localparam int RANDOM_PHASES   = 8;
  localparam int BEAMS_PER_PHASE = 105;
  // indexes with no register behind them
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE     = 8'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_LAST_CODE = 8'hFF;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [47:0]            s_tdata   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [55:0]            m_tdata;
  logic                   m_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  int          fail_count;
  int          points_due;
  int          points_seen;
  int          valid_seen;
  int          settings_used = 1;
  logic [15:0] win_lo        = 16'd0;
  logic [15:0] win_hi        = 16'hFFFF;
  int          stall_mode    = 0;
  int          stall_left    = 0;

  always #5 clk = ~clk;

  laser_polar_to_cartesian_top #(
    .CORDIC_STAGES(CORDIC_STAGES),
    .INDEX_BITS   (INDEX_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  lpc_point_checker #(
    .CORDIC_STAGES(CORDIC_STAGES),
    .INDEX_BITS   (INDEX_BITS)
  ) u_point_chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (points_due),
    .points_seen(points_seen),
    .valid_seen (valid_seen)
  );

  // Receiver: switches between free flow, light, periodic and heavy stalls
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(50, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= ($urandom_range(0, 3) != 0);
      2:       m_tready <= (stall_left % 3 != 0);
      default: m_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // Stop sending and wait until every point is out, then some idle cycles
  task automatic drain(input int extra);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (points_due != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [23:0] val,
                           input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic load_settings(input logic [23:0] lo, input logic [23:0] hi,
                               input logic [23:0] start, input logic [23:0] step);
    drain(PIPE_CYCLES + 2);
    write_reg(REG_MIN_RANGE, lo, 1'b0);
    write_reg(REG_MAX_RANGE, hi, 1'b0);
    write_reg(REG_START_ANGLE, start, 1'b0);
    write_reg(REG_ANGLE_STEP, step, 1'b1);
    win_lo = lo[15:0];
    win_hi = hi[15:0];
    settings_used++;
  endtask

  // Leaves tvalid high; the caller lowers it only when a gap follows
  task automatic send_beam(input logic [11:0] idx, input logic [15:0] rng,
                           input logic [15:0] strength);
    s_tvalid <= 1'b1;
    s_tdata  <= {4'd0, strength, rng, idx};
    do @(posedge clk); while (!s_tready);
  endtask

  // Ranges cluster around the window edges now and then
  function automatic logic [15:0] pick_range();
    case ($urandom_range(0, 7))
      0:       return 16'(win_lo - 16'd1 + 16'($urandom_range(0, 2)));
      1:       return 16'(win_hi - 16'd1 + 16'($urandom_range(0, 2)));
      2:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [11:0] pick_index();
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
    return 12'($urandom);
  endfunction

  // One phase of random beams in bursts; hold_at >= 0 pauses for a full drain
  task automatic run_beams(input int n, input bit gaps_on, input int hold_at);
    int burst;
    burst = $urandom_range(1, 40);
    for (int k = 0; k < n; k++) begin
      if (k == hold_at) drain(0);
      send_beam(pick_index(), pick_range(), 16'($urandom));
      burst--;
      if (gaps_on && burst == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst = $urandom_range(1, 40);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset window: both range limits are exclusive
    send_beam(12'h000, 16'd0, 16'hFFFF);
    send_beam(12'hFFF, 16'd1, 16'h0000);
    send_beam(12'h000, 16'hFFFE, 16'hFFFF);
    send_beam(12'h001, 16'hFFFF, 16'd1234);

    // Quarter-turn steps land exactly on each quadrant
    load_settings(24'd0, 24'hFFFF, 24'd0, 24'h400000);
    for (int k = 0; k < 5; k++) send_beam(12'(k), 16'hFFFE, 16'($urandom));
    send_beam(12'hFFF, 16'hFFFE, 16'hFFFF);

    // Angle wraps past one turn; upper data bits of range writes are dropped
    load_settings(24'hFF0000, 24'hABFFFF, 24'hFFFFFF, 24'hFFFFFF);
    write_reg(REG_SPARE, 24'h00FFFF, 1'b0);
    write_reg(REG_LAST_CODE, 24'hFFFFFF, 1'b1);
    send_beam(12'hFFF, 16'd40000, 16'h5A5A);
    send_beam(12'h001, 16'd40000, 16'hA5A5);
    send_beam(12'h000, 16'd40000, 16'hFFFF);

    // Empty windows: min equal to max, then min above max
    load_settings(24'd1000, 24'd1000, 24'd0, 24'd0);
    send_beam(12'h000, 16'd999, 16'd7);
    send_beam(12'h000, 16'd1000, 16'd7);
    send_beam(12'h000, 16'd1001, 16'd7);
    load_settings(24'hFFFF, 24'd0, 24'd0, 24'd0);
    send_beam(12'h123, 16'd32768, 16'd9);

    // Just short of each quadrant boundary
    load_settings(24'd0, 24'hFFFF, 24'h3FFFFF, 24'h400000);
    for (int k = 0; k < 4; k++) send_beam(12'(k), 16'hFFFE, 16'($urandom));

    // Random phases, extremes first
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: load_settings(24'd0, 24'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
        1: load_settings(24'hFFFF, 24'd0, 24'($urandom), 24'($urandom));
        2: load_settings(24'd0, 24'hFFFF, 24'd0, 24'd1);
        default: load_settings(24'($urandom_range(0, 4000)), 24'($urandom_range(20000, 65535)),
                               24'($urandom),
                               $urandom_range(0, 1) ? 24'($urandom_range(0, 8192))
                                                    : 24'($urandom));
      endcase
      run_beams(BEAMS_PER_PHASE, (p % 4) != 3,
                (p % 2 == 0) ? $urandom_range(10, BEAMS_PER_PHASE - 10) : -1);
    end

    drain(PIPE_CYCLES + 5);
    $display("Run covered %0d beams, %0d inside the range window, over %0d register settings,",
             points_seen, valid_seen, settings_used);
    $display("with quadrant edges, angle wrap, empty windows, sender gaps and receiver stalls.");
    if (fail_count == 0 && points_due == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/lpc_pkg.sv
sv/lpc_angle.sv
sv/lpc_cordic.sv
sv/lpc_scale.sv
sv/lpc_out_buf.sv
sv/laser_polar_to_cartesian_top.sv
sv/lpc_checker.sv
dv/lpc_point_checker.sv
dv/laser_polar_to_cartesian_top_tb.sv
